[rtl/pip_pkg.sv]
// shared constants, codes and controller/datapath interface types for the point-in-polygon test
package pip_pkg;

   localparam int MAX_VERTICES = 128;
   localparam int COORD_BITS   = 12;

   localparam int FIELD_W      = 12;
   localparam int COUNT_W      = 8;
   localparam int MODE_W       = 2;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 16;

   localparam int IDX_BITS     = $clog2(MAX_VERTICES);
   localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
   localparam int WALK_BITS    = $clog2(MAX_VERTICES + 2);
   localparam int DIFF_W       = COORD_BITS + 1;
   localparam int PROD_W       = 2 * DIFF_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_TEST   = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef struct packed {
      logic accept;
      logic clear;
      logic append;
      logic test_start;
      logic issue;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic pipe_busy;
   } status_type;

endpackage

[rtl/pip_ctrl.sv]
// controller state machine: transfer handshakes and sequencing of the edge walk
module pip_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pip_pkg::mode_type    mode,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pip_pkg::cmd_type     cmd,
   input  pip_pkg::status_type  status
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_WALK  = 4'b0010,
      S_DRAIN = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (mode)
                  pip_pkg::MODE_CLEAR:  cmd.clear      = 1'b1;
                  pip_pkg::MODE_APPEND: cmd.append     = 1'b1;
                  pip_pkg::MODE_TEST:   cmd.test_start = 1'b1;
                  default: ;
               endcase
               state_in = (mode == pip_pkg::MODE_TEST) ? S_WALK : S_RESP;
            end
         end
         S_WALK: begin
            if (status.walk_done) begin
               state_in = S_DRAIN;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // a new item never meets reads still in flight from the previous walk
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !status.pipe_busy)
      else $error("pip_ctrl: pipeline busy while idle");

   // a loaded result is presented on the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("pip_ctrl: loaded result not valid");

   // no read is issued once the walk counter has run out
   a_issue_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !status.walk_done)
      else $error("pip_ctrl: read issued past end of walk");
`endif

endmodule

[rtl/pip_dp.sv]
// datapath: vertex memory, vertex count, pipelined edge crossing test and result register
module pip_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pip_pkg::cmd_type                     cmd,
   input  logic [pip_pkg::FIELD_W-1:0]          x_coord,
   input  logic [pip_pkg::FIELD_W-1:0]          y_coord,
   output pip_pkg::status_type                  status,
   output logic                                 inside_res,
   output logic [pip_pkg::COUNT_W-1:0]          vertex_count,
   output logic                                 store_full
);

   localparam int CB = pip_pkg::COORD_BITS;

   // vertex memory, y in the upper half
   logic [2*CB-1:0] vert_mem [pip_pkg::MAX_VERTICES];

   logic [pip_pkg::CNT_BITS-1:0]  count_ff;
   logic [pip_pkg::CNT_BITS-1:0]  cnt_dec;
   logic                          has_room;
   logic                          full_flag_ff;
   logic                          odd_ff;
   logic [CB-1:0]                 px_ff, py_ff;

   logic [pip_pkg::IDX_BITS-1:0]  rd_addr_ff;
   logic [pip_pkg::WALK_BITS-1:0] rd_left_ff;
   logic                          issue_first_ff;

   logic                          rd_vld_ff, rd_first_ff;
   logic [2*CB-1:0]               mem_q_ff;
   logic [2*CB-1:0]               prev_ff;

   logic                          e_vld_ff, strad_ff, dypos_ff;
   logic signed [pip_pkg::PROD_W-1:0] lhs_ff, rhs_ff;

   logic                          rsp_inside_ff, rsp_full_ff;
   logic [pip_pkg::COUNT_W-1:0]   rsp_count_ff;

   // edge terms: a is the current vertex, b the previous one
   logic [CB-1:0]                     xa_u, ya_u, xb_u, yb_u;
   logic signed [pip_pkg::DIFF_W-1:0] xa, ya, xb, yb, pxs, pys;
   logic signed [pip_pkg::DIFF_W-1:0] dy, dxe, dpy, dpx;
   logic signed [pip_pkg::PROD_W-1:0] lhs, rhs;
   logic                              strad, flip;

   assign cnt_dec  = count_ff - pip_pkg::CNT_BITS'(1);
   assign has_room = (count_ff < pip_pkg::CNT_BITS'(pip_pkg::MAX_VERTICES));

   // count, flags and walk bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rd_left_ff <= '0;
      end else begin
         if (cmd.clear) begin
            count_ff <= '0;
         end else if (cmd.append && has_room) begin
            count_ff <= count_ff + pip_pkg::CNT_BITS'(1);
         end
         if (cmd.test_start) begin
            rd_left_ff <= (count_ff == '0) ? '0 :
               pip_pkg::WALK_BITS'(count_ff) + pip_pkg::WALK_BITS'(1);
         end else if (cmd.issue) begin
            rd_left_ff <= rd_left_ff - pip_pkg::WALK_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         full_flag_ff <= cmd.append && !has_room;
         px_ff        <= x_coord[CB-1:0];
         py_ff        <= y_coord[CB-1:0];
      end
      if (cmd.test_start) begin
         rd_addr_ff     <= cnt_dec[pip_pkg::IDX_BITS-1:0];
         issue_first_ff <= 1'b1;
      end else if (cmd.issue) begin
         rd_addr_ff     <= issue_first_ff ? '0 : rd_addr_ff + pip_pkg::IDX_BITS'(1);
         issue_first_ff <= 1'b0;
      end
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.append && has_room) begin
         vert_mem[count_ff[pip_pkg::IDX_BITS-1:0]] <= {y_coord[CB-1:0], x_coord[CB-1:0]};
      end
      if (cmd.issue) begin
         mem_q_ff <= vert_mem[rd_addr_ff];
      end
   end

   // stage b: edge terms and products
   assign xa_u = mem_q_ff[CB-1:0];
   assign ya_u = mem_q_ff[2*CB-1:CB];
   assign xb_u = prev_ff[CB-1:0];
   assign yb_u = prev_ff[2*CB-1:CB];
   assign xa   = $signed({1'b0, xa_u});
   assign ya   = $signed({1'b0, ya_u});
   assign xb   = $signed({1'b0, xb_u});
   assign yb   = $signed({1'b0, yb_u});
   assign pxs  = $signed({1'b0, px_ff});
   assign pys  = $signed({1'b0, py_ff});
   assign dy   = yb - ya;
   assign dxe  = xb - xa;
   assign dpy  = pys - ya;
   assign dpx  = pxs - xa;
   assign lhs  = dpy * dxe;
   assign rhs  = dpx * dy;
   assign strad = ((ya_u < py_ff) && (yb_u >= py_ff)) || ((yb_u < py_ff) && (ya_u >= py_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         e_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
         e_vld_ff  <= rd_vld_ff && !rd_first_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_first_ff <= issue_first_ff;
      end
      if (rd_vld_ff) begin
         prev_ff  <= mem_q_ff;
         strad_ff <= strad;
         dypos_ff <= (yb > ya);
         lhs_ff   <= lhs;
         rhs_ff   <= rhs;
      end
   end

   // stage c: crossing compare, sense set by the sign of the y span
   assign flip = strad_ff && (dypos_ff ? (lhs_ff < rhs_ff) : (lhs_ff > rhs_ff));

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         odd_ff <= 1'b0;
      end else if (e_vld_ff && flip) begin
         odd_ff <= ~odd_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_inside_ff <= odd_ff;
         rsp_count_ff  <= pip_pkg::COUNT_W'(count_ff);
         rsp_full_ff   <= full_flag_ff;
      end
   end

   assign status.walk_done = (rd_left_ff == '0);
   assign status.pipe_busy = rd_vld_ff || e_vld_ff;
   assign inside_res       = rsp_inside_ff;
   assign vertex_count     = rsp_count_ff;
   assign store_full       = rsp_full_ff;

endmodule

[rtl/point_in_polygon_test.sv]
// top level of the point-in-polygon test (ray casting, even-odd rule)
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/req_tready | tuser: mode; tdata: x_coord, y_coord
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: inside_res, vertex_count, store_full
//
//  clear, append and unused mode: one result, loaded in the result state after the accept
//  test with n vertices: one memory read port reads the last vertex then each
//    vertex once, one edge per cycle
//  one item at a time; a new item is taken while the previous result waits in
//    the output register
//  reset is synchronous, active high; the vertex count starts at zero and the
//    vertex memory has no reset
//  a stalled result holds the block in its result state until the output
//    register frees up
module point_in_polygon_test (
   input  logic                              clock,
   input  logic                              reset,
   // req transfer
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pip_pkg::MODE_W-1:0]        req_tuser,  // [1:0] mode
   input  logic [pip_pkg::REQ_DATA_W-1:0]    req_tdata,  // [11:0] x_coord, [23:12] y_coord
   // rsp transfer
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pip_pkg::RSP_DATA_W-1:0]    rsp_tdata   // [0] inside_res, [8:1] vertex_count,
                                                         // [9] store_full, [15:10] zero
);

   pip_pkg::cmd_type              cmd;
   pip_pkg::status_type           status;
   logic                          inside_res;
   logic [pip_pkg::COUNT_W-1:0]   vertex_count;
   logic                          store_full;

   // sequencer: handshakes and walk control
   pip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .mode      (pip_pkg::mode_type'(req_tuser)),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .status    (status)
   );

   // vertex store, edge pipeline and result register
   pip_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .x_coord      (req_tdata[pip_pkg::FIELD_W-1:0]),
      .y_coord      (req_tdata[2*pip_pkg::FIELD_W-1:pip_pkg::FIELD_W]),
      .status       (status),
      .inside_res   (inside_res),
      .vertex_count (vertex_count),
      .store_full   (store_full)
   );

   // pack result fields from bit zero up, zero fill to bit 15
   assign rsp_tdata = {
      (pip_pkg::RSP_DATA_W - pip_pkg::COUNT_W - 2)'(0),
      store_full,
      vertex_count,
      inside_res
   };

endmodule

[verif/pip_checker.sv]
// checker for the point-in-polygon test: watches both channels, predicts each answer and compares
`timescale 1ns / 100ps

module pip_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [pip_pkg::MODE_W-1:0]     req_tuser,   // [1:0] mode
   input  logic [pip_pkg::REQ_DATA_W-1:0] req_tdata,   // [11:0] x_coord, [23:12] y_coord
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [pip_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [0] inside_res, [8:1] vertex_count,
                                                       // [9] store_full
   output int                             mismatch_total,
   output int                             answers_pending
);

   typedef struct packed {
      logic                        in_poly;
      logic [pip_pkg::COUNT_W-1:0] count;
      logic                        full;
   } poly_answer_type;

   logic [pip_pkg::FIELD_W-1:0] corner_x [pip_pkg::MAX_VERTICES];
   logic [pip_pkg::FIELD_W-1:0] corner_y [pip_pkg::MAX_VERTICES];
   int                          corner_total;
   poly_answer_type             predicted_answers [$];
   int                          mismatches;

   // even-odd ray cast, exact cross-multiplied crossing test
   function automatic logic ray_cast_inside(input longint px, input longint py);
      logic   odd;
      logic   crosses;
      int     i;
      int     j;
      longint xa, ya, xb, yb, dy, lhs, rhs;
      odd = 1'b0;
      if (corner_total == 0)
         return 1'b0;
      j = corner_total - 1;
      for (i = 0; i < corner_total; i++) begin
         xa = longint'(corner_x[i]);
         ya = longint'(corner_y[i]);
         xb = longint'(corner_x[j]);
         yb = longint'(corner_y[j]);
         if ((ya < py && yb >= py) || (yb < py && ya >= py)) begin
            dy      = yb - ya;
            lhs     = (py - ya) * (xb - xa);
            rhs     = (px - xa) * dy;
            crosses = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
            if (crosses)
               odd = ~odd;
         end
         j = i;
      end
      return odd;
   endfunction

   // updates the polygon copy and returns the answer for one request
   function automatic poly_answer_type apply_request(input pip_pkg::mode_type m,
                                                     input logic [pip_pkg::FIELD_W-1:0] x,
                                                     input logic [pip_pkg::FIELD_W-1:0] y);
      poly_answer_type a;
      a = '0;
      case (m)
         pip_pkg::MODE_CLEAR: begin
            corner_total = 0;
         end
         pip_pkg::MODE_APPEND: begin
            if (corner_total < pip_pkg::MAX_VERTICES) begin
               corner_x[corner_total] = x;
               corner_y[corner_total] = y;
               corner_total++;
            end else begin
               a.full = 1'b1;
            end
         end
         pip_pkg::MODE_TEST: begin
            a.in_poly = ray_cast_inside(longint'(x), longint'(y));
         end
         default: ;
      endcase
      a.count = pip_pkg::COUNT_W'(corner_total);
      return a;
   endfunction

   always @(posedge clock) begin : watch
      poly_answer_type got;
      poly_answer_type want;
      if (reset) begin
         corner_total = 0;
         mismatches   = 0;
         predicted_answers.delete();
      end else begin
         // answers first: a request taken at this edge cannot answer at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.in_poly = rsp_tdata[0];
            got.count   = rsp_tdata[8:1];
            got.full    = rsp_tdata[9];
            if (predicted_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: answer with none pending: inside %0d count %0d full %0d",
                           $realtime, got.in_poly, got.count, got.full);
            end else begin
               want = predicted_answers.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: expected inside %0d count %0d full %0d,",
                               " got inside %0d count %0d full %0d"},
                              $realtime, want.in_poly, want.count, want.full,
                              got.in_poly, got.count, got.full);
               end
            end
         end
         if (req_tvalid && req_tready)
            predicted_answers.push_back(
               apply_request(pip_pkg::mode_type'(req_tuser),
                             req_tdata[pip_pkg::FIELD_W-1:0],
                             req_tdata[2*pip_pkg::FIELD_W-1:pip_pkg::FIELD_W]));
      end
      mismatch_total  <= mismatches;
      answers_pending <= predicted_answers.size();
   end

endmodule

[verif/point_in_polygon_test_tb.sv]
// testbench top for the point-in-polygon test: stimulus, back-pressure and verdict
`timescale 1ns / 100ps

module point_in_polygon_test_tb;

   localparam int DIRECTED_ITEMS = 23;
   localparam int RANDOM_ITEMS   = 700;
   localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + RANDOM_ITEMS;
   localparam int QUIET_ITEMS    = 80;      // last stretch runs with no idling
   localparam int HOLD_AFTER     = 150;     // transfers before the long receiver hold-off
   localparam int HOLD_CYCLES    = 300;
   // limit on the whole run, counted from the start of simulation
   localparam int CYCLE_LIMIT    = 600000;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [pip_pkg::MODE_W-1:0]     req_tuser;   // [1:0] mode
   logic [pip_pkg::REQ_DATA_W-1:0] req_tdata;   // [11:0] x_coord, [23:12] y_coord
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [pip_pkg::RSP_DATA_W-1:0] rsp_tdata;   // [0] inside_res, [8:1] vertex_count,
                                                // [9] store_full

   int mismatch_total;
   int answers_pending;

   // stimulus bookkeeping
   int  items_sent     = 0;
   int  send_idle_pct  = 0;
   bit  quiet          = 0;
   bit  long_hold_done = 0;
   int  cycle_count    = 0;

   // mirror of the vertex store, used only to aim test points
   logic [pip_pkg::FIELD_W-1:0] shape_x [pip_pkg::MAX_VERTICES];
   logic [pip_pkg::FIELD_W-1:0] shape_y [pip_pkg::MAX_VERTICES];
   int                          shape_n = 0;
   logic [pip_pkg::FIELD_W-1:0] cluster_x;
   logic [pip_pkg::FIELD_W-1:0] cluster_y;

   point_in_polygon_test u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pip_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_total  (mismatch_total),
      .answers_pending (answers_pending)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run guard: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("point_in_polygon_test: mismatch");
         $finish;
      end
   end

   function automatic logic [pip_pkg::FIELD_W-1:0] any_coord();
      return pip_pkg::FIELD_W'($urandom_range(0, 4095));
   endfunction

   // vertex coordinate in one of several flavors: anywhere, coarse grid
   // (lots of shared y values and collinear edges), tight cluster, extremes
   function automatic logic [pip_pkg::FIELD_W-1:0] pick_coord(input int style,
                                                             input bit y_axis);
      int g;
      case (style)
         1: begin
            g = $urandom_range(0, 16) * 256;
            return (g > 4095) ? 12'd4095 : pip_pkg::FIELD_W'(g);
         end
         2: return (y_axis ? cluster_y : cluster_x) +
                   pip_pkg::FIELD_W'($urandom_range(0, 15));
         3: begin
            case ($urandom_range(0, 4))
               0: return 12'd0;
               1: return 12'd1;
               2: return 12'd2048;
               3: return 12'd4094;
               default: return 12'd4095;
            endcase
         end
         default: return any_coord();
      endcase
   endfunction

   // one request transfer; an idle burst may come first, valid stays up while stalled
   task automatic send_item(input pip_pkg::mode_type m,
                            input logic [pip_pkg::FIELD_W-1:0] x,
                            input logic [pip_pkg::FIELD_W-1:0] y);
      int gap;
      quiet = (items_sent >= TOTAL_ITEMS - QUIET_ITEMS);
      if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic clear_polygon();
      send_item(pip_pkg::MODE_CLEAR, any_coord(), any_coord());
      shape_n = 0;
   endtask

   task automatic append_vertex(input logic [pip_pkg::FIELD_W-1:0] x,
                                input logic [pip_pkg::FIELD_W-1:0] y);
      send_item(pip_pkg::MODE_APPEND, x, y);
      // appends to a full store are dropped by the block, so the mirror saturates too
      if (shape_n < pip_pkg::MAX_VERTICES) begin
         shape_x[shape_n] = x;
         shape_y[shape_n] = y;
         shape_n++;
      end
   endtask

   task automatic add_vertex(input int style);
      append_vertex(pick_coord(style, 1'b0), pick_coord(style, 1'b1));
   endtask

   task automatic build_polygon(input int n);
      int k;
      int style;
      style     = $urandom_range(0, 3);
      cluster_x = pip_pkg::FIELD_W'($urandom_range(0, 4080));
      cluster_y = pip_pkg::FIELD_W'($urandom_range(0, 4080));
      clear_polygon();
      for (k = 0; k < n; k++)
         add_vertex(style);
   endtask

   // test points aimed at the current polygon: anywhere, inside its bounding box,
   // on a vertex, on a vertex's y (ray through a vertex), on an edge midpoint
   task automatic probe_polygon(input int count);
      int                          k;
      int                          v;
      int                          style;
      logic [pip_pkg::FIELD_W-1:0] lo_x, hi_x, lo_y, hi_y;
      logic [pip_pkg::FIELD_W-1:0] x, y;
      lo_x = 12'd4095;
      lo_y = 12'd4095;
      hi_x = 12'd0;
      hi_y = 12'd0;
      for (k = 0; k < shape_n; k++) begin
         if (shape_x[k] < lo_x) lo_x = shape_x[k];
         if (shape_x[k] > hi_x) hi_x = shape_x[k];
         if (shape_y[k] < lo_y) lo_y = shape_y[k];
         if (shape_y[k] > hi_y) hi_y = shape_y[k];
      end
      for (k = 0; k < count; k++) begin
         style = (shape_n == 0) ? 0 : $urandom_range(0, 4);
         v     = (shape_n == 0) ? 0 : $urandom_range(0, shape_n - 1);
         case (style)
            1: begin
               x = pip_pkg::FIELD_W'($urandom_range(lo_x, hi_x));
               y = pip_pkg::FIELD_W'($urandom_range(lo_y, hi_y));
            end
            2: begin
               x = shape_x[v];
               y = shape_y[v];
            end
            3: begin
               x = pip_pkg::FIELD_W'($urandom_range(lo_x, hi_x));
               y = shape_y[v];
            end
            4: begin
               x = pip_pkg::FIELD_W'(({1'b0, shape_x[v]} + shape_x[(v + 1) % shape_n]) >> 1);
               y = pip_pkg::FIELD_W'(({1'b0, shape_y[v]} + shape_y[(v + 1) % shape_n]) >> 1);
            end
            default: begin
               x = any_coord();
               y = any_coord();
            end
         endcase
         send_item(pip_pkg::MODE_TEST, x, y);
      end
   endtask

   // receiver: random short stalls in stretches, one long hold-off so the
   // block backs up and drops req_tready, nothing in the last stretch
   initial begin : receiver
      int stall_pct;
      int stretch_left;
      int burst;
      stall_pct    = 0;
      stretch_left = 0;
      rsp_tready   = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stretch_left == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 20;
               default: stall_pct = 50;
            endcase
            stretch_left = 64;
         end
         stretch_left--;
         if (!long_hold_done && items_sent >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold_done = 1;
         end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            burst = $urandom_range(1, 8);
            rsp_tready <= 1'b0;
            repeat (burst) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int seq_num;
      int pick;
      int r;
      int n;
      req_tvalid = 1'b0;
      req_tuser  = pip_pkg::MODE_NOP;
      req_tdata  = '0;
      reset      = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed part ---
      // empty polygon, unused mode
      send_item(pip_pkg::MODE_TEST, 12'd4095, 12'd4095);
      send_item(pip_pkg::MODE_NOP, 12'd0, 12'd0);
      // one vertex, then two (same edge walked twice): always outside
      append_vertex(12'd0, 12'd0);
      send_item(pip_pkg::MODE_TEST, 12'd0, 12'd0);
      append_vertex(12'd4095, 12'd4095);
      send_item(pip_pkg::MODE_TEST, 12'd2000, 12'd2000);
      // triangle at the corners, horizontal edge along y = 0
      append_vertex(12'd4095, 12'd0);
      send_item(pip_pkg::MODE_TEST, 12'd4000, 12'd100);
      send_item(pip_pkg::MODE_TEST, 12'd0, 12'd4095);
      send_item(pip_pkg::MODE_TEST, 12'd4095, 12'd4095);
      send_item(pip_pkg::MODE_TEST, 12'd2048, 12'd0);
      // unused mode with all data bits set, then clear and test
      send_item(pip_pkg::MODE_NOP, 12'd4095, 12'd4095);
      send_item(pip_pkg::MODE_CLEAR, 12'd4095, 12'd4095);
      shape_n = 0;
      send_item(pip_pkg::MODE_TEST, 12'd1500, 12'd1500);
      // square with two horizontal edges; points inside, outside, on bottom, right and left sides
      append_vertex(12'd100, 12'd100);
      append_vertex(12'd3000, 12'd100);
      append_vertex(12'd3000, 12'd3000);
      append_vertex(12'd100, 12'd3000);
      send_item(pip_pkg::MODE_TEST, 12'd1500, 12'd1500);
      send_item(pip_pkg::MODE_TEST, 12'd1500, 12'd100);
      send_item(pip_pkg::MODE_TEST, 12'd99, 12'd1500);
      send_item(pip_pkg::MODE_TEST, 12'd3000, 12'd1500);
      send_item(pip_pkg::MODE_TEST, 12'd100, 12'd1500);

      // --- random part ---
      seq_num = 0;
      while (items_sent < TOTAL_ITEMS) begin
         case ($urandom_range(0, 2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 15;
            default: send_idle_pct = 40;
         endcase
         pick = $urandom_range(0, 99);
         if (seq_num == 12 || pick < 2) begin
            // fill the store and push a few appends past full
            build_polygon(pip_pkg::MAX_VERTICES + $urandom_range(1, 3));
            probe_polygon($urandom_range(3, 6));
         end else if (pick < 70) begin
            r = $urandom_range(0, 99);
            if (r < 5)
               n = $urandom_range(0, 2);
            else if (r < 88)
               n = $urandom_range(3, 10);
            else
               n = $urandom_range(11, 40);
            build_polygon(n);
            probe_polygon($urandom_range(2, 8));
         end else if (pick < 82) begin
            probe_polygon($urandom_range(1, 4));
         end else if (pick < 91) begin
            // grow the current polygon without clearing
            repeat ($urandom_range(1, 4)) add_vertex($urandom_range(0, 3));
            probe_polygon(2);
         end else begin
            // noise: unused mode with random data, sometimes a clear and a test
            repeat ($urandom_range(1, 3))
               send_item(pip_pkg::MODE_NOP, any_coord(), any_coord());
            if ($urandom_range(0, 2) == 0) begin
               clear_polygon();
               probe_polygon(1);
            end
         end
         seq_num++;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then a short settle for any stray answer
      while (answers_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_total == 0)
         $display("point_in_polygon_test: match");
      else
         $display("point_in_polygon_test: mismatch");
      $finish;
   end

endmodule
